@@ rtl/msmrc_pkg.sv @@
// msmrc_pkg: shared constants of the motion and skin mask run classifier
// register indexes, register reset values and default sizes
// no dependencies
`timescale 1ns / 1ps

package msmrc_pkg;

    localparam int DEF_MAX_COUNT = 1023;
    localparam int DEF_MAX_ROWS  = 1024;

    localparam int IDX_W = 3;
    localparam int DAT_W = 11;
    localparam int KEY_W = 11;

    localparam logic [IDX_W-1:0] REG_DIFF_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_RUN_MIN        = 3'd1;
    localparam logic [IDX_W-1:0] REG_RUN_MAX        = 3'd2;
    localparam logic [IDX_W-1:0] REG_CORNER_LIMIT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_MOTION_LIMIT   = 3'd4;

    localparam logic [7:0]  RST_DIFF_THRESHOLD = 8'd50;
    localparam logic [6:0]  RST_RUN_MIN        = 7'd20;
    localparam logic [6:0]  RST_RUN_MAX        = 7'd80;
    localparam logic [10:0] RST_CORNER_LIMIT   = 11'd100;
    localparam logic [9:0]  RST_MOTION_LIMIT   = 10'd300;

    localparam logic [6:0] RUN_SAT = 7'd127;

    localparam logic [1:0] CLASS_CORNER = 2'd0;
    localparam logic [1:0] CLASS_CENTER = 2'd1;
    localparam logic [1:0] CLASS_MOTION = 2'd2;

    localparam logic [13:0] GRAY_WB = 14'd1868;
    localparam logic [13:0] GRAY_WG = 14'd9617;
    localparam logic [13:0] GRAY_WR = 14'd4899;
    localparam logic [22:0] GRAY_RND = 23'd8192;

    localparam logic [7:0] SKIN_R_MIN  = 8'd95;
    localparam logic [7:0] SKIN_G_MIN  = 8'd40;
    localparam logic [7:0] SKIN_B_MIN  = 8'd20;
    localparam logic [7:0] SKIN_SPREAD = 8'd15;

endpackage

@@ rtl/motion_skin_mask_run_classifier_unit.sv @@
// motion_skin_mask_run_classifier_unit: per pixel foreground mask, row run count
// and frame end histogram mode classifier; histogram held in one sync memory
// depends on msmrc_pkg
//
//   channel | handshake             | words
//   in      | in_valid / in_stall   | cur_*, bg_*, row_end, frame_end
//   out     | out_valid / out_stall | mask_bit, class_valid, gesture_class, mode_key
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// per pixel S_MUL, S_GRAY, S_DONE; S_BUMP too at row end, count nonzero (bin read, write)
// at frame end the histogram memory is read once per bin for the mode and zeroed
// behind the read in S_SCAN and S_SCAN_END, followed by S_CLASS
// after reset a clearing pass over every bin (S_CLEAR) runs before in_stall drops
// a new pixel is taken while the previous result waits in the output register
`timescale 1ns / 1ps

module motion_skin_mask_run_classifier_unit #(
    parameter int MAX_COUNT = msmrc_pkg::DEF_MAX_COUNT,
    parameter int MAX_ROWS  = msmrc_pkg::DEF_MAX_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      cur_blue,
    input  logic [7:0]                      cur_green,
    input  logic [7:0]                      cur_red,
    input  logic [7:0]                      bg_blue,
    input  logic [7:0]                      bg_green,
    input  logic [7:0]                      bg_red,
    input  logic                            row_end,
    input  logic                            frame_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            mask_bit,
    output logic                            class_valid,
    output logic [1:0]                      gesture_class,
    output logic signed [msmrc_pkg::KEY_W-1:0] mode_key,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [msmrc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [msmrc_pkg::DAT_W-1:0]     cfg_data
);

    localparam int DEPTH = MAX_COUNT + 1;
    localparam int KW    = $clog2(DEPTH);
    localparam int BW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = (KW + 2 > 12) ? KW + 2 : 12;
    localparam logic [KW-1:0] LAST_IDX = KW'(MAX_COUNT);
    localparam logic [BW-1:0] BIN_SAT  = BW'(MAX_ROWS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_GRAY, S_BUMP, S_SCAN, S_SCAN_END, S_CLASS, S_DONE
    } state_t;

    state_t state_reg;

    logic [7:0]  diff_threshold_reg;
    logic [6:0]  run_min_reg;
    logic [6:0]  run_max_reg;
    logic signed [10:0] corner_limit_reg;
    logic [9:0]  motion_limit_reg;

    logic [7:0]  db_reg, dg_reg, dr_reg;
    logic        skin_reg, row_end_reg, frame_end_reg;
    logic [21:0] pb_reg, pg_reg, pr_reg;
    logic        fg_reg;

    logic        in_run_reg;
    logic [6:0]  run_length_reg;
    logic [KW-1:0] count_reg;

    logic [KW-1:0] idx_reg, addr_d_reg, bump_addr_reg;
    logic        rd_pend_reg;
    logic [BW-1:0] best_reg;
    logic [KW-1:0] key_reg;
    logic        found_reg;
    logic        cls_valid_reg;
    logic [1:0]  cls_reg;
    logic signed [CW-1:0] key_cmp_reg;

    logic        out_valid_reg, mask_reg, class_valid_reg;
    logic [1:0]  gesture_reg;
    logic signed [msmrc_pkg::KEY_W-1:0] mode_key_reg;

    logic [BW-1:0] mem [DEPTH];
    logic [BW-1:0] mem_rd_reg;
    logic          mem_we;
    logic [KW-1:0] mem_wa, mem_ra;
    logic [BW-1:0] mem_wd;

    logic [7:0]  abs_b, abs_g, abs_r, mx, mn, rg;
    logic        skin;
    logic [22:0] gray_sum;
    logic [8:0]  gray;
    logic        fg, close_ok, bump;
    logic        in_run_next;
    logic [6:0]  run_length_next;
    logic [KW-1:0] count_next;
    logic        better;
    logic signed [CW-1:0] key_x, corner_x, motion_x;
    logic        out_free;
    logic        out_load;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign mask_bit  = mask_reg;
    assign class_valid   = class_valid_reg;
    assign gesture_class = gesture_reg;
    assign mode_key      = mode_key_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == S_DONE) && out_free;

    // pixel front end
    always_comb
    begin
        abs_b = (cur_blue  > bg_blue)  ? cur_blue  - bg_blue  : bg_blue  - cur_blue;
        abs_g = (cur_green > bg_green) ? cur_green - bg_green : bg_green - cur_green;
        abs_r = (cur_red   > bg_red)   ? cur_red   - bg_red   : bg_red   - cur_red;
        mx = cur_red;
        if (cur_green > mx) mx = cur_green;
        if (cur_blue > mx) mx = cur_blue;
        mn = cur_red;
        if (cur_green < mn) mn = cur_green;
        if (cur_blue < mn) mn = cur_blue;
        rg = (cur_red > cur_green) ? cur_red - cur_green : cur_green - cur_red;
        skin = (cur_red > msmrc_pkg::SKIN_R_MIN) && (cur_green > msmrc_pkg::SKIN_G_MIN)
            && (cur_blue > msmrc_pkg::SKIN_B_MIN) && ((mx - mn) > msmrc_pkg::SKIN_SPREAD)
            && (rg > msmrc_pkg::SKIN_SPREAD) && (cur_red > cur_green)
            && (cur_red > cur_blue);
    end

    // gray, run tracking, count
    always_comb
    begin
        gray_sum = 23'(pb_reg) + 23'(pg_reg) + 23'(pr_reg) + msmrc_pkg::GRAY_RND;
        gray = gray_sum[22:14];
        fg = (gray > {1'b0, diff_threshold_reg}) || skin_reg;
        close_ok = (run_length_reg > run_min_reg) && (run_length_reg < run_max_reg)
            && (count_reg < LAST_IDX);
        in_run_next = in_run_reg;
        run_length_next = run_length_reg;
        count_next = count_reg;
        if (fg)
        begin
            if (!in_run_reg)
            begin
                in_run_next = 1'b1;
                run_length_next = 7'd1;
            end
            else if (run_length_reg < msmrc_pkg::RUN_SAT)
            begin
                run_length_next = run_length_reg + 7'd1;
            end
        end
        else if (in_run_reg)
        begin
            if (close_ok) count_next = count_reg + KW'(1);
            in_run_next = 1'b0;
            run_length_next = 7'd0;
        end
        bump = (row_end_reg || frame_end_reg) && (count_next != '0);
        better = rd_pend_reg && (mem_rd_reg > best_reg);
    end

    // class compare
    always_comb
    begin
        key_x    = found_reg ? CW'($signed({1'b0, key_reg})) : '1;
        corner_x = CW'(corner_limit_reg);
        motion_x = CW'($signed({1'b0, motion_limit_reg}));
    end

    // memory port control
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = idx_reg;
        mem_wd = '0;
        mem_ra = idx_reg;
        case (state_reg)
            S_CLEAR: mem_we = 1'b1;
            S_GRAY: mem_ra = count_next;
            S_BUMP:
            begin
                mem_we = 1'b1;
                mem_wa = bump_addr_reg;
                mem_wd = (mem_rd_reg < BIN_SAT) ? mem_rd_reg + BW'(1) : mem_rd_reg;
            end
            S_SCAN, S_SCAN_END:
            begin
                mem_we = rd_pend_reg;
                mem_wa = addr_d_reg;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        mem_rd_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            diff_threshold_reg <= msmrc_pkg::RST_DIFF_THRESHOLD;
            run_min_reg <= msmrc_pkg::RST_RUN_MIN;
            run_max_reg <= msmrc_pkg::RST_RUN_MAX;
            corner_limit_reg <= msmrc_pkg::RST_CORNER_LIMIT;
            motion_limit_reg <= msmrc_pkg::RST_MOTION_LIMIT;
            in_run_reg <= 1'b0;
            run_length_reg <= '0;
            count_reg <= '0;
            idx_reg <= '0;
            rd_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    msmrc_pkg::REG_DIFF_THRESHOLD: diff_threshold_reg <= cfg_data[7:0];
                    msmrc_pkg::REG_RUN_MIN:        run_min_reg <= cfg_data[6:0];
                    msmrc_pkg::REG_RUN_MAX:        run_max_reg <= cfg_data[6:0];
                    msmrc_pkg::REG_CORNER_LIMIT:   corner_limit_reg <= $signed(cfg_data[10:0]);
                    msmrc_pkg::REG_MOTION_LIMIT:   motion_limit_reg <= cfg_data[9:0];
                    default: ;
                endcase
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
            if (better)
            begin
                best_reg <= mem_rd_reg;
                key_reg <= addr_d_reg;
                found_reg <= 1'b1;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + KW'(1);
                    if (idx_reg == LAST_IDX) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        db_reg <= abs_b;
                        dg_reg <= abs_g;
                        dr_reg <= abs_r;
                        skin_reg <= skin;
                        row_end_reg <= row_end;
                        frame_end_reg <= frame_end;
                        cls_valid_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    pb_reg <= 22'(db_reg) * 22'(msmrc_pkg::GRAY_WB);
                    pg_reg <= 22'(dg_reg) * 22'(msmrc_pkg::GRAY_WG);
                    pr_reg <= 22'(dr_reg) * 22'(msmrc_pkg::GRAY_WR);
                    state_reg <= S_GRAY;
                end
                S_GRAY:
                begin
                    fg_reg <= fg;
                    in_run_reg <= (row_end_reg || frame_end_reg) ? 1'b0 : in_run_next;
                    run_length_reg <= (row_end_reg || frame_end_reg) ? 7'd0 : run_length_next;
                    count_reg <= count_next;
                    bump_addr_reg <= count_next;
                    best_reg <= '0;
                    found_reg <= 1'b0;
                    idx_reg <= '0;
                    if (bump) state_reg <= S_BUMP;
                    else if (frame_end_reg) state_reg <= S_SCAN;
                    else state_reg <= S_DONE;
                end
                S_BUMP:
                begin
                    state_reg <= frame_end_reg ? S_SCAN : S_DONE;
                end
                S_SCAN:
                begin
                    rd_pend_reg <= 1'b1;
                    addr_d_reg <= idx_reg;
                    idx_reg <= idx_reg + KW'(1);
                    if (idx_reg == LAST_IDX) state_reg <= S_SCAN_END;
                end
                S_SCAN_END:
                begin
                    rd_pend_reg <= 1'b0;
                    idx_reg <= '0;
                    state_reg <= S_CLASS;
                end
                S_CLASS:
                begin
                    key_cmp_reg <= key_x;
                    if (key_x <= corner_x) cls_reg <= msmrc_pkg::CLASS_CORNER;
                    else if (key_x > motion_x) cls_reg <= msmrc_pkg::CLASS_MOTION;
                    else cls_reg <= msmrc_pkg::CLASS_CENTER;
                    cls_valid_reg <= 1'b1;
                    count_reg <= '0;
                    in_run_reg <= 1'b0;
                    run_length_reg <= '0;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        mask_reg <= fg_reg;
                        class_valid_reg <= cls_valid_reg;
                        gesture_reg <= cls_valid_reg ? cls_reg : msmrc_pkg::CLASS_CORNER;
                        mode_key_reg <= cls_valid_reg ? msmrc_pkg::KEY_W'(key_cmp_reg) : '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

@@ sim/tb_motion_skin_mask_run_classifier_unit.sv @@
// tb_motion_skin_mask_run_classifier_unit: random and directed pixel streams against a
// cycle-free predictor of the mask, row run count and frame-end mode classification
// depends on msmrc_pkg and motion_skin_mask_run_classifier_unit
`timescale 1ns / 1ps

module tb_motion_skin_mask_run_classifier_unit;

    localparam int HIST_N = msmrc_pkg::DEF_MAX_COUNT + 1;
    localparam int CYCLE_LIMIT = 900000;
    localparam logic [msmrc_pkg::IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic [7:0] cb;
        logic [7:0] cg;
        logic [7:0] cr;
        logic [7:0] bb;
        logic [7:0] bgr;
        logic [7:0] br;
        logic       re;
        logic       fe;
    } pixel_t;

    typedef struct packed {
        logic               mask;
        logic               cvalid;
        logic [1:0]         cls;
        logic signed [10:0] key;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] cur_blue, cur_green, cur_red, bg_blue, bg_green, bg_red;
    logic row_end, frame_end;
    logic out_valid;
    logic out_stall;
    logic mask_bit, class_valid;
    logic [1:0] gesture_class;
    logic signed [msmrc_pkg::KEY_W-1:0] mode_key;
    logic cfg_valid;
    logic cfg_ready;
    logic [msmrc_pkg::IDX_W-1:0] cfg_index;
    logic [msmrc_pkg::DAT_W-1:0] cfg_data;

    motion_skin_mask_run_classifier_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cur_blue(cur_blue), .cur_green(cur_green), .cur_red(cur_red),
        .bg_blue(bg_blue), .bg_green(bg_green), .bg_red(bg_red),
        .row_end(row_end), .frame_end(frame_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .mask_bit(mask_bit), .class_valid(class_valid),
        .gesture_class(gesture_class), .mode_key(mode_key),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    int unsigned thr_q, rmin_q, rmax_q, mlim_q;
    int          clim_q;
    bit          run_open;
    int unsigned run_len;
    int unsigned frame_runs;
    int unsigned row_hist [HIST_N];

    pixel_t   pixel_q [$];
    verdict_t verdict_q [$];
    int  send_idle_pct, recv_idle_pct;
    bit  hold_recv;
    int  hold_left;
    int  errors;
    int  cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned absd(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic bit is_skin(input int b, input int g, input int r);
        int mx, mn, rg;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        rg = (r > g) ? r - g : g - r;
        return r > 95 && g > 40 && b > 20 && (mx - mn) > 15 && rg > 15 && r > g && r > b;
    endfunction

    function automatic verdict_t predict_pixel(input pixel_t p);
        verdict_t v;
        int unsigned gray, best;
        int key;
        bit fg;
        gray = (1868 * absd(p.cb, p.bb) + 9617 * absd(p.cg, p.bgr)
                + 4899 * absd(p.cr, p.br) + 8192) >> 14;
        fg = gray > thr_q || is_skin(p.cb, p.cg, p.cr);
        if (fg)
        begin
            if (!run_open)
            begin
                run_open = 1'b1;
                run_len = 1;
            end
            else if (run_len < 127)
                run_len++;
        end
        else if (run_open)
        begin
            if (run_len > rmin_q && run_len < rmax_q && frame_runs < msmrc_pkg::DEF_MAX_COUNT)
                frame_runs++;
            run_open = 1'b0;
            run_len = 0;
        end
        if (p.re || p.fe)
        begin
            run_open = 1'b0;
            run_len = 0;
            if (frame_runs != 0 && row_hist[frame_runs] < msmrc_pkg::DEF_MAX_ROWS)
                row_hist[frame_runs]++;
        end
        v = '0;
        v.mask = fg;
        if (p.fe)
        begin
            best = 0;
            key = -1;
            for (int k = 0; k < HIST_N; k++)
                if (row_hist[k] > best)
                begin
                    best = row_hist[k];
                    key = k;
                end
            if (key <= clim_q) v.cls = msmrc_pkg::CLASS_CORNER;
            else if (key > int'(mlim_q)) v.cls = msmrc_pkg::CLASS_MOTION;
            else v.cls = msmrc_pkg::CLASS_CENTER;
            v.cvalid = 1'b1;
            v.key = key[10:0];
            for (int k = 0; k < HIST_N; k++) row_hist[k] = 0;
            frame_runs = 0;
        end
        return v;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (!in_valid || !in_stall)
            begin
                if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    {cur_blue, cur_green, cur_red, bg_blue, bg_green, bg_red,
                     row_end, frame_end} <= pixel_q[0];
                    verdict_q.push_back(predict_pixel(pixel_q[0]));
                    pixel_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall and long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_recv)
        begin
            out_stall <= 1'b1;
            hold_left <= 400;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                e = verdict_q.pop_front();
                if (mask_bit !== e.mask)
                begin
                    $error("mask_bit exp %0d got %0d", e.mask, mask_bit);
                    errors++;
                end
                if (class_valid !== e.cvalid)
                begin
                    $error("class_valid exp %0d got %0d", e.cvalid, class_valid);
                    errors++;
                end
                if (gesture_class !== e.cls)
                begin
                    $error("gesture_class exp %0d got %0d", e.cls, gesture_class);
                    errors++;
                end
                if (mode_key !== e.key)
                begin
                    $error("mode_key exp %0d got %0d", e.key, mode_key);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("motion_skin_mask_run_classifier_unit verification failed");
            $finish;
        end
    end

    task automatic wait_drain();
        while (pixel_q.size() > 0 || verdict_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (msmrc_pkg::DEF_MAX_COUNT + 20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [msmrc_pkg::IDX_W-1:0] idx,
                             input logic [msmrc_pkg::DAT_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            msmrc_pkg::REG_DIFF_THRESHOLD: thr_q = val[7:0];
            msmrc_pkg::REG_RUN_MIN:        rmin_q = val[6:0];
            msmrc_pkg::REG_RUN_MAX:        rmax_q = val[6:0];
            msmrc_pkg::REG_CORNER_LIMIT:   clim_q = $signed(val[10:0]);
            msmrc_pkg::REG_MOTION_LIMIT:   mlim_q = val[9:0];
            default: ;
        endcase
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p = pixel_t'({$urandom, $urandom});
        p.re = 1'b0;
        p.fe = 1'b0;
        return p;
    endfunction

    // foreground pixels with a large diff or plain background
    function automatic pixel_t shaped_pixel(input bit fg);
        pixel_t p;
        p = rand_pixel();
        if (fg)
        begin
            p.cg = 8'd255;
            p.bgr = 8'd0;
        end
        else
        begin
            p.cr = 8'd10;
            p.bb = p.cb;
            p.bgr = p.cg;
            p.br = p.cr;
        end
        return p;
    endfunction

    task automatic add_frame(input int rows, input int width);
        pixel_t p;
        int len;
        for (int r = 0; r < rows; r++)
        begin
            for (int c = 0; c < width; c++)
            begin
                if ($urandom_range(9) == 0) p = rand_pixel();
                else
                begin
                    len = (c / 6) % 2;
                    p = shaped_pixel(len == 0);
                end
                p.re = (c == width - 1);
                p.fe = (c == width - 1) && (r == rows - 1);
                pixel_q.push_back(p);
            end
        end
    endtask

    initial
    begin
        pixel_t p;
        errors = 0;
        cycles = 0;
        hold_recv = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 46;
        in_valid = 1'b0;
        cur_blue = '0; cur_green = '0; cur_red = '0;
        bg_blue = '0; bg_green = '0; bg_red = '0;
        row_end = 1'b0; frame_end = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        thr_q = msmrc_pkg::RST_DIFF_THRESHOLD;
        rmin_q = msmrc_pkg::RST_RUN_MIN;
        rmax_q = msmrc_pkg::RST_RUN_MAX;
        clim_q = $signed(msmrc_pkg::RST_CORNER_LIMIT);
        mlim_q = msmrc_pkg::RST_MOTION_LIMIT;
        run_open = 1'b0; run_len = 0; frame_runs = 0;
        for (int k = 0; k < HIST_N; k++) row_hist[k] = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, skin edges, empty frame, frame end without row end
        pixel_q.push_back('0);
        pixel_q.push_back({8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0});
        pixel_q.push_back({8'd21, 8'd41, 8'd96, 8'd21, 8'd41, 8'd96, 1'b0, 1'b0});
        pixel_q.push_back({8'd20, 8'd40, 8'd95, 8'd20, 8'd40, 8'd95, 1'b0, 1'b0});
        pixel_q.push_back({8'd30, 8'd81, 8'd96, 8'd30, 8'd81, 8'd96, 1'b0, 1'b0});
        pixel_q.push_back({8'd30, 8'd80, 8'd96, 8'd30, 8'd80, 8'd96, 1'b1, 1'b0});
        pixel_q.push_back({8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1});
        pixel_q.push_back({48'h0, 1'b0, 1'b1});
        wait_drain();
        write_reg(msmrc_pkg::REG_RUN_MIN, 11'd0);
        write_reg(msmrc_pkg::REG_RUN_MAX, 11'd4);
        write_reg(msmrc_pkg::REG_CORNER_LIMIT, 11'h7ff);
        write_reg(msmrc_pkg::REG_MOTION_LIMIT, 11'd0);
        // runs of 1..3 counted, one left open at row end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 10; c++)
            begin
                p = shaped_pixel(c % 3 != 2);
                p.re = (c == 9);
                p.fe = (c == 9) && (r == 3);
                pixel_q.push_back(p);
            end
        end
        wait_drain();

        // random phases under different settings
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 37;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(msmrc_pkg::REG_DIFF_THRESHOLD,
                      (ph == 1) ? 11'd255 : (ph == 3 ? 11'd0 : 11'd60));
            write_reg(msmrc_pkg::REG_RUN_MIN, (ph == 5) ? 11'd127 : 11'($urandom_range(3)));
            write_reg(msmrc_pkg::REG_RUN_MAX,
                      (ph == 0) ? 11'd127 : 11'($urandom_range(4, 12)));
            write_reg(msmrc_pkg::REG_CORNER_LIMIT,
                      (ph % 2) ? 11'd1023 : 11'($urandom_range(0, 3)));
            write_reg(msmrc_pkg::REG_MOTION_LIMIT,
                      (ph == 2) ? 11'd1023 : 11'($urandom_range(2, 6)));
            write_reg(REG_NONE, 11'($urandom));
            for (int f = 0; f < 6; f++)
                add_frame($urandom_range(1, 6), $urandom_range(4, 12));
            for (int i = 0; i < 40; i++)
            begin
                p = rand_pixel();
                p.re = ($urandom_range(7) == 0);
                p.fe = ($urandom_range(30) == 0);
                pixel_q.push_back(p);
            end
            if (ph == 4)
            begin
                hold_recv = 1'b1;
                wait (hold_left > 0);
                hold_recv = 1'b0;
            end
            wait_drain();
        end

        if (errors == 0)
            $display("motion_skin_mask_run_classifier_unit verification clean");
        else
            $display("motion_skin_mask_run_classifier_unit verification failed");
        $finish;
    end

endmodule
